FILE: rtl/cbm_pkg.sv
package cbm_pkg;

  typedef enum logic [2:0] {
    REQ_CPU_RD = 3'd0,
    REQ_CPU_WR = 3'd1,
    REQ_PPU_RD = 3'd2,
    REQ_PPU_WR = 3'd3,
    REQ_TICK   = 3'd4,
    REQ_IRQ_CLR = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DIV  = 2'b10
  } state_e;

  // CPU write key: {addr[15:12], addr[4]}
  localparam logic [4:0] KEY_PRG0  = 5'b10000;
  localparam logic [4:0] KEY_PRG1  = 5'b10001;
  localparam logic [4:0] KEY_PRG2  = 5'b10010;
  localparam logic [4:0] KEY_SND   = 5'b10011;
  localparam logic [4:0] KEY_CHR0  = 5'b10100;
  localparam logic [4:0] KEY_CHR7  = 5'b11011;
  localparam logic [4:0] KEY_MIRR  = 5'b11100;
  localparam logic [4:0] KEY_LATCH = 5'b11101;
  localparam logic [4:0] KEY_CTRL  = 5'b11110;
  localparam logic [4:0] KEY_ACK   = 5'b11111;

  localparam logic [0:0] CFG_PRG_COUNT = 1'b0;
  localparam logic [0:0] CFG_CHR_COUNT = 1'b1;

  localparam logic [9:0] DIV_RELOAD    = 10'd341;
  localparam logic [9:0] DIV_STEP      = 10'd3;
  localparam logic [5:0] PRG_COUNT_RST = 6'd32;
  localparam logic [5:0] PRG_LAST_RST  = 6'd62;

endpackage

FILE: rtl/cartridge_bank_mapper_with_irq.sv
// A banked read (CPU $8000-$DFFF, PPU pattern access) strobes its result once the 8-step
// shared remainder unit reduces the bank number; other items strobe in the next cycle.
// The unit takes no new item while it works: busy_o is high during the steps and start_i
// is ignored until the block is idle; other items leave the block idle for a new request.
// Reset is asynchronous, active low; control state resets at once, the datapath does not.
// Results are shown for one cycle with result_valid_o; the receiver cannot stall.
module cartridge_bank_mapper_with_irq (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  req_type_i,
  input  logic [15:0] addr_i,
  input  logic [7:0]  wdata_i,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [5:0]  cfg_wdata_i,
  output logic        result_valid_o,
  output logic        handled_o,
  output logic [18:0] xlat_addr_o,
  output logic [1:0]  mirror_mode_o,
  output logic        irq_line_o
);
  import cbm_pkg::*;

  state_e      state_q;
  logic [5:0]  prg_cnt_q, chr_cnt_q;
  logic [5:0]  prg_sel_q [3];
  logic [7:0]  chr_sel_q [8];
  logic [1:0]  mirr_q;
  logic        irq_en_q, irq_eaa_q, irq_pend_q;
  logic [7:0]  irq_latch_q, irq_cnt_q;
  logic [9:0]  irq_div_q;

  logic [7:0]  dvd_q;
  logic [8:0]  dvs_q, rem_q;
  logic [2:0]  step_q;
  logic        is_prg_q;
  logic [12:0] off_q;

  logic        done_q, handled_q;
  logic [18:0] mapped_q;

  logic        accept;
  req_e        req;
  logic [4:0]  key;
  logic [2:0]  chr_slot;
  logic [6:0]  prg_total;
  logic [5:0]  prg_fixed;
  logic        cpu_rd_bank, ppu_map, need_div;
  logic [7:0]  dvd_in;
  logic [8:0]  dvs_in;
  logic        imm_handled;
  logic [18:0] imm_mapped;
  logic [9:0]  trial;
  logic [8:0]  rem_nxt;

  assign accept   = start_i && (state_q == S_IDLE);
  assign busy_o   = (state_q == S_DIV);
  assign req      = req_e'(req_type_i);
  assign key      = {addr_i[15:12], addr_i[4]};
  assign chr_slot = 3'(key - KEY_CHR0);

  assign prg_total = (prg_cnt_q == 6'd0) ? 7'd1 : {prg_cnt_q, 1'b0};
  assign prg_fixed = 6'(prg_total - 7'd1);

  assign cpu_rd_bank = (req == REQ_CPU_RD) && addr_i[15] && (addr_i[15:13] != 3'b111);
  assign ppu_map = (addr_i[15:13] == 3'b000) &&
                   ((req == REQ_PPU_RD) || ((req == REQ_PPU_WR) && (chr_cnt_q == 6'd0)));
  assign need_div = cpu_rd_bank || ppu_map;

  always_comb begin
    if (cpu_rd_bank) begin
      dvs_in = {2'b00, prg_total};
      dvd_in = {2'b00, addr_i[14] ? prg_sel_q[2] : (addr_i[13] ? prg_sel_q[1] : prg_sel_q[0])};
    end else begin
      dvs_in = (chr_cnt_q == 6'd0) ? 9'd8 : {chr_cnt_q, 3'b000};
      dvd_in = chr_sel_q[addr_i[12:10]];
    end
  end

  // results that need no bank reduction
  always_comb begin
    imm_handled = 1'b0;
    imm_mapped  = '0;
    case (req)
      REQ_CPU_RD: begin
        if (addr_i[15]) begin
          imm_handled = 1'b1;
          imm_mapped  = {prg_fixed, addr_i[12:0]};
        end
      end
      REQ_CPU_WR: imm_handled = addr_i[15];
      default: ;
    endcase
  end

  // one restoring remainder step
  assign trial   = {rem_q, dvd_q[7]};
  assign rem_nxt = (trial >= {1'b0, dvs_q}) ? 9'(trial - {1'b0, dvs_q}) : trial[8:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      done_q     <= 1'b0;
      step_q     <= '0;
      prg_cnt_q  <= PRG_COUNT_RST;
      chr_cnt_q  <= '0;
      prg_sel_q[0] <= 6'd0;
      prg_sel_q[1] <= 6'd1;
      prg_sel_q[2] <= PRG_LAST_RST;
      for (int i = 0; i < 8; i++) begin
        chr_sel_q[i] <= 8'(i);
      end
      mirr_q      <= '0;
      irq_en_q    <= 1'b0;
      irq_eaa_q   <= 1'b0;
      irq_pend_q  <= 1'b0;
      irq_latch_q <= '0;
      irq_cnt_q   <= '0;
      irq_div_q   <= DIV_RELOAD;
    end else begin
      done_q <= 1'b0;

      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_PRG_COUNT) begin
          prg_cnt_q <= cfg_wdata_i;
        end else begin
          chr_cnt_q <= cfg_wdata_i;
        end
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (need_div) begin
              state_q <= S_DIV;
              step_q  <= 3'd7;
            end else begin
              done_q <= 1'b1;
            end
            case (req)
              REQ_CPU_WR: begin
                if (addr_i[15]) begin
                  unique case (key) inside
                    KEY_PRG0:  prg_sel_q[0] <= wdata_i[5:0];
                    KEY_PRG1:  prg_sel_q[1] <= wdata_i[5:0];
                    KEY_PRG2:  prg_sel_q[2] <= wdata_i[5:0];
                    KEY_SND:   ;
                    [KEY_CHR0:KEY_CHR7]: chr_sel_q[chr_slot] <= wdata_i;
                    KEY_MIRR:  mirr_q <= wdata_i[1:0];
                    KEY_LATCH: irq_latch_q <= wdata_i;
                    KEY_CTRL: begin
                      irq_en_q   <= wdata_i[1];
                      irq_eaa_q  <= wdata_i[0];
                      irq_pend_q <= 1'b0;
                      if (wdata_i[1]) begin
                        irq_cnt_q <= irq_latch_q;
                        irq_div_q <= DIV_RELOAD;
                      end
                    end
                    KEY_ACK: begin
                      irq_pend_q <= 1'b0;
                      irq_en_q   <= irq_eaa_q;
                    end
                    default: ;
                  endcase
                end
              end
              REQ_TICK: begin
                if (irq_en_q) begin
                  if (irq_div_q <= DIV_STEP) begin
                    irq_div_q <= irq_div_q + DIV_RELOAD - DIV_STEP;
                    if (irq_cnt_q == 8'hFF) begin
                      irq_cnt_q  <= irq_latch_q;
                      irq_pend_q <= 1'b1;
                    end else begin
                      irq_cnt_q <= irq_cnt_q + 8'd1;
                    end
                  end else begin
                    irq_div_q <= irq_div_q - DIV_STEP;
                  end
                end
              end
              REQ_IRQ_CLR: irq_pend_q <= 1'b0;
              default: ;
            endcase
          end
        end
        S_DIV: begin
          step_q <= step_q - 3'd1;
          if (step_q == 3'd0) begin
            state_q <= S_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath: divider operands and result registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      dvd_q     <= dvd_in;
      dvs_q     <= dvs_in;
      rem_q     <= '0;
      is_prg_q  <= cpu_rd_bank;
      off_q     <= addr_i[12:0];
      handled_q <= imm_handled;
      mapped_q  <= imm_mapped;
    end else if (state_q == S_DIV) begin
      dvd_q <= {dvd_q[6:0], 1'b0};
      rem_q <= rem_nxt;
      if (step_q == 3'd0) begin
        handled_q <= 1'b1;
        mapped_q  <= is_prg_q ? {rem_nxt[5:0], off_q} : {rem_nxt, off_q[9:0]};
      end
    end
  end

  assign result_valid_o = done_q;
  assign handled_o      = handled_q;
  assign xlat_addr_o    = mapped_q;
  assign mirror_mode_o  = mirr_q;
  assign irq_line_o     = irq_pend_q;

  a_unhandled_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !handled_o) |-> (xlat_addr_o == '0))
    else $error("unhandled item carries a nonzero address");

  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && need_div) |=> (busy_o && !result_valid_o))
    else $error("banked read did not enter the remainder steps");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_o && (step_q == 3'd0)) |=> (result_valid_o && handled_o && !busy_o))
    else $error("last remainder step did not deliver a result");

  a_imm_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !need_div) |=> (result_valid_o && !busy_o))
    else $error("direct item did not deliver next cycle");

  a_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req == REQ_IRQ_CLR)) |=> !irq_line_o)
    else $error("interrupt clear left pending set");

endmodule
